// File: hdl/sfb_pkg.sv
`timescale 1ns / 1ps
package sfb_pkg;

    // FIR length is fixed by the coefficient register map
    localparam int TAP_COUNT  = 5;
    localparam int FIR_CNT_W  = $clog2(TAP_COUNT + 1);
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int SAT_IN_W   = 20;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Coefficient register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IIR_OLD_GAIN  = 3'd0,
        REG_IIR_NEW_GAIN  = 3'd1,
        REG_FIR_TAP_ZERO  = 3'd2,
        REG_FIR_TAP_ONE   = 3'd3,
        REG_FIR_TAP_TWO   = 3'd4,
        REG_FIR_TAP_THREE = 3'd5,
        REG_FIR_TAP_FOUR  = 3'd6
    } t_reg_idx;

    // Q1.15 reset weights
    localparam t_sample IIR_OLD_GAIN_RST  = 16'sd6554;
    localparam t_sample IIR_NEW_GAIN_RST  = 16'sd26214;
    localparam t_sample FIR_TAP_ZERO_RST  = 16'sd0;
    localparam t_sample FIR_TAP_ONE_RST   = 16'sd6675;
    localparam t_sample FIR_TAP_TWO_RST   = 16'sd19418;
    localparam t_sample FIR_TAP_THREE_RST = 16'sd6675;
    localparam t_sample FIR_TAP_FOUR_RST  = 16'sd0;

    // Coefficient set shared by the IIR and FIR filters; fir_tap[0] weighs the oldest sample
    typedef struct packed {
        t_sample                 iir_old_gain;
        t_sample                 iir_new_gain;
        t_sample [TAP_COUNT-1:0] fir_tap;
    } t_coef;

    // Clamp a rounded value to the signed 16-bit range
    function automatic t_sample sat16(input logic signed [SAT_IN_W-1:0] v);
        if (v > 20'sd32767) begin
            return 16'sh7fff;
        end else if (v < -20'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// File: hdl/sfb_cfg_regs.sv
`timescale 1ns / 1ps
module sfb_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [sfb_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [sfb_pkg::SAMPLE_W-1:0]  i_data,
    output sfb_pkg::t_coef             o_coef
);
    import sfb_pkg::*;

    t_coef r_coef;

    // Load reset weights, then take writes by register index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.iir_old_gain <= IIR_OLD_GAIN_RST;
            r_coef.iir_new_gain <= IIR_NEW_GAIN_RST;
            r_coef.fir_tap[0]   <= FIR_TAP_ZERO_RST;
            r_coef.fir_tap[1]   <= FIR_TAP_ONE_RST;
            r_coef.fir_tap[2]   <= FIR_TAP_TWO_RST;
            r_coef.fir_tap[3]   <= FIR_TAP_THREE_RST;
            r_coef.fir_tap[4]   <= FIR_TAP_FOUR_RST;
        end else if (i_wr) begin
            case (t_reg_idx'(i_index))
                REG_IIR_OLD_GAIN:  r_coef.iir_old_gain <= i_data;
                REG_IIR_NEW_GAIN:  r_coef.iir_new_gain <= i_data;
                REG_FIR_TAP_ZERO:  r_coef.fir_tap[0]   <= i_data;
                REG_FIR_TAP_ONE:   r_coef.fir_tap[1]   <= i_data;
                REG_FIR_TAP_TWO:   r_coef.fir_tap[2]   <= i_data;
                REG_FIR_TAP_THREE: r_coef.fir_tap[3]   <= i_data;
                REG_FIR_TAP_FOUR:  r_coef.fir_tap[4]   <= i_data;
                default: begin
                    // drop writes beyond the register map
                end
            endcase
        end
    end

    assign o_coef = r_coef;

endmodule

// File: hdl/sfb_average.sv
`timescale 1ns / 1ps
module sfb_average #(
    parameter int AVERAGE_LENGTH = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  sfb_pkg::t_sample i_sample,
    output sfb_pkg::t_sample o_average
);
    import sfb_pkg::*;

    localparam int CNT_W     = $clog2(AVERAGE_LENGTH + 1);
    localparam int SUM_W     = SAMPLE_W + $clog2(AVERAGE_LENGTH);
    // Reciprocal scale: exact floor division for any dividend below 2**SUM_W
    localparam int DIV_SHIFT = SUM_W + $clog2(AVERAGE_LENGTH);
    localparam int PROD_W    = SUM_W + DIV_SHIFT;
    localparam int QUOT_W    = SAMPLE_W + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(AVERAGE_LENGTH) - 64'd1) / 64'(AVERAGE_LENGTH);
    localparam logic [DIV_SHIFT-1:0] RECIP = DIV_SHIFT'(RECIP_FULL);
    localparam logic [SUM_W-1:0]     HALF  = SUM_W'(AVERAGE_LENGTH / 2);

    t_sample                  r_ring [AVERAGE_LENGTH];
    logic signed [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]         r_count;

    logic signed [SUM_W-1:0]  n_sum;
    logic                     w_neg;
    logic [SUM_W-1:0]         w_abs;
    logic [SUM_W-1:0]         w_mag;
    logic [PROD_W-1:0]        w_prod;
    logic [QUOT_W-1:0]        w_quot;
    logic [QUOT_W-1:0]        w_signed;
    logic                     w_warm;

    // Running sum: add the new sample, drop the oldest
    assign n_sum = r_sum + SUM_W'(i_sample) - SUM_W'(r_ring[0]);

    // Round half away from zero on the magnitude, divide by reciprocal multiply
    assign w_neg    = n_sum[SUM_W-1];
    assign w_abs    = w_neg ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    assign w_mag    = w_abs + HALF;
    assign w_prod   = PROD_W'(w_mag) * PROD_W'(RECIP);
    assign w_quot   = w_prod[DIV_SHIFT +: QUOT_W];
    assign w_signed = w_neg ? QUOT_W'(-w_quot) : w_quot;

    assign w_warm    = r_count < CNT_W'(AVERAGE_LENGTH);
    assign o_average = w_warm ? i_sample : w_signed[SAMPLE_W-1:0];

    // Shift the ring, update sum and saturating count on each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AVERAGE_LENGTH; i++) begin
                r_ring[i] <= '0;
            end
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_step) begin
            for (int i = 0; i < AVERAGE_LENGTH - 1; i++) begin
                r_ring[i] <= r_ring[i+1];
            end
            r_ring[AVERAGE_LENGTH-1] <= i_sample;
            r_sum <= n_sum;
            if (w_warm) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

endmodule

// File: hdl/sfb_iir.sv
`timescale 1ns / 1ps
module sfb_iir (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  sfb_pkg::t_sample i_sample,
    input  sfb_pkg::t_coef   i_coef,
    output sfb_pkg::t_sample o_smoothed
);
    import sfb_pkg::*;

    localparam int ACC_W = 34;
    localparam int RND_W = ACC_W - 15;

    t_sample                 r_prev;
    logic signed [31:0]      w_p_old;
    logic signed [31:0]      w_p_new;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [RND_W-1:0] w_rnd;

    // Mix previous output with the new sample, round to nearest, clamp
    assign w_p_old = 32'($signed(i_coef.iir_old_gain)) * 32'(r_prev);
    assign w_p_new = 32'($signed(i_coef.iir_new_gain)) * 32'(i_sample);
    assign w_acc   = ACC_W'(w_p_old) + ACC_W'(w_p_new) + 34'sd16384;
    assign w_rnd   = w_acc[ACC_W-1:15];

    assign o_smoothed = sat16(SAT_IN_W'(w_rnd));

    // Hold the last output as the feedback term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_step) begin
            r_prev <= o_smoothed;
        end
    end

endmodule

// File: hdl/sfb_fir.sv
`timescale 1ns / 1ps
module sfb_fir (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  sfb_pkg::t_sample i_sample,
    input  sfb_pkg::t_coef   i_coef,
    output sfb_pkg::t_sample o_weighted
);
    import sfb_pkg::*;

    localparam int ACC_W = 35;

    t_sample                 r_win [TAP_COUNT];
    logic [FIR_CNT_W-1:0]    r_count;

    t_sample                 w_win [TAP_COUNT];
    logic signed [31:0]      w_prod [TAP_COUNT];
    logic signed [ACC_W-1:0] w_acc;
    logic signed [SAT_IN_W-1:0] w_rnd;
    logic                    w_warm;

    // Window after this item enters, oldest first
    always_comb begin
        for (int i = 0; i < TAP_COUNT - 1; i++) begin
            w_win[i] = r_win[i+1];
        end
        w_win[TAP_COUNT-1] = i_sample;
    end

    // Weighted sum with round-to-nearest offset
    always_comb begin
        w_acc = 35'sd16384;
        for (int i = 0; i < TAP_COUNT; i++) begin
            w_prod[i] = 32'($signed(i_coef.fir_tap[i])) * 32'(w_win[i]);
            w_acc     = w_acc + ACC_W'(w_prod[i]);
        end
    end

    assign w_rnd      = w_acc[ACC_W-1:15];
    assign w_warm     = r_count < FIR_CNT_W'(TAP_COUNT);
    assign o_weighted = w_warm ? i_sample : sat16(w_rnd);

    // Advance the window and saturating count on each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAP_COUNT; i++) begin
                r_win[i] <= '0;
            end
            r_count <= '0;
        end else if (i_step) begin
            for (int i = 0; i < TAP_COUNT; i++) begin
                r_win[i] <= w_win[i];
            end
            if (w_warm) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

endmodule

// File: hdl/sensor_filter_bank_top.sv
`timescale 1ns / 1ps
// Filter bank for a signed 16-bit sensor stream: each accepted sample yields one result
// with a moving average over the last AVERAGE_LENGTH samples (ties away from zero), a
// first-order IIR output and a five-tap FIR output, both with Q1.15 weights, rounded to
// nearest and clamped to 16 bits. Until a filter has seen its full length of samples,
// the average and FIR outputs pass the current sample through. One sample is taken
// every clock cycle while the output is not stalled; a sample is captured in the input
// register at the edge that accepts it, and its result appears when it moves into the
// result register. The rate is set by the IIR feedback loop, which closes
// combinationally through two 16x16 multiplies, an add, rounding and the clamp.
// Coefficient registers are written through the cfg port (index 0 to 6, writes to
// other indexes are dropped) and should only change while no sample is in flight.
module sensor_filter_bank_top #(
    parameter int AVERAGE_LENGTH = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sfb_pkg::SAMPLE_W-1:0]  i_sample_in,
    // result output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sfb_pkg::SAMPLE_W-1:0]  o_average_out,
    output logic [sfb_pkg::SAMPLE_W-1:0]  o_smoothed_out,
    output logic [sfb_pkg::SAMPLE_W-1:0]  o_weighted_out,
    // coefficient write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfb_pkg::SAMPLE_W-1:0]  i_cfg_data
);
    import sfb_pkg::*;

    logic    r_in_valid;
    t_sample r_sample;
    logic    r_out_valid;
    t_sample r_average;
    t_sample r_smoothed;
    t_sample r_weighted;

    logic    w_advance;
    logic    w_in_take;
    t_coef   w_coef;
    t_sample w_average;
    t_sample w_smoothed;
    t_sample w_weighted;

    // Move an item into the result register when it is empty or being drained
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign w_in_take  = !r_in_valid || w_advance;
    assign o_in_stall = !w_in_take;

    assign o_cfg_ready = 1'b1;

    sfb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_coef  (w_coef)
    );

    sfb_average #(
        .AVERAGE_LENGTH (AVERAGE_LENGTH)
    ) u_average (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_advance),
        .i_sample  (r_sample),
        .o_average (w_average)
    );

    sfb_iir u_iir (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_sample   (r_sample),
        .i_coef     (w_coef),
        .o_smoothed (w_smoothed)
    );

    sfb_fir u_fir (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_sample   (r_sample),
        .i_coef     (w_coef),
        .o_weighted (w_weighted)
    );

    // Track occupancy of the input and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the incoming sample and the finished results
    always_ff @(posedge i_clk) begin
        if (w_in_take && i_in_valid) begin
            r_sample <= t_sample'(i_sample_in);
        end
        if (w_advance) begin
            r_average  <= w_average;
            r_smoothed <= w_smoothed;
            r_weighted <= w_weighted;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_average_out  = r_average;
    assign o_smoothed_out = r_smoothed;
    assign o_weighted_out = r_weighted;

    // A full input register behind a stalled result must hold off new transactions
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_in_valid) |-> o_in_stall)
        else $error("input accepted while both registers are full and stalled");

    // A new result only comes from an item waiting in the input register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a pending item");

    // A drained result with nothing behind it leaves the output empty
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !r_in_valid) |=> !o_out_valid)
        else $error("result repeated after transaction completed");

endmodule

// File: tb/tb_sensor_filter_bank_top.sv
`timescale 1ns / 1ps
module tb_sensor_filter_bank_top;
    import sfb_pkg::*;

    localparam int AVG_LEN        = 5;
    localparam int NUM_REGS       = TAP_COUNT + 2;
    localparam int RAND_PHASES    = 6;
    localparam int RAND_PER_PHASE = 280;
    // a correct run never goes this long without a transaction, even at 84% stall
    localparam int STALL_LIMIT    = 2000;

    // index just past the register map; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam t_sample RESET_GAINS [NUM_REGS] = '{
        IIR_OLD_GAIN_RST, IIR_NEW_GAIN_RST, FIR_TAP_ZERO_RST, FIR_TAP_ONE_RST,
        FIR_TAP_TWO_RST, FIR_TAP_THREE_RST, FIR_TAP_FOUR_RST
    };

    typedef struct packed {
        t_sample average;
        t_sample smoothed;
        t_sample weighted;
    } t_filter_result;

    typedef struct packed {
        bit             typed;
        t_filter_result res;
    } t_sample_mark;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        t_sample                value;
        bit                     typed;
        t_filter_result         res;
    } t_dir_row;

    localparam t_filter_result NO_RES = '0;
    localparam int DIR_ROWS = 25;

    // Directed rows: warm-up, field extremes, then saturating weights.
    // Sample rows carry REG_SPARE in the unused index slot.
    t_dir_row dir_table [DIR_ROWS] = '{
        '{ROW_SAMPLE, REG_SPARE, 16'sd0, 1'b1, '{16'sd0, 16'sd0, 16'sd0}},
        '{ROW_SAMPLE, REG_SPARE, 16'sh7fff, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, 16'sh8000, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, 16'sd1, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, -16'sd1, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, 16'sd100, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, 16'shaaaa, 1'b0, NO_RES},
        '{ROW_WRITE, REG_IIR_OLD_GAIN, 16'sd0, 1'b0, NO_RES},
        '{ROW_WRITE, REG_IIR_NEW_GAIN, 16'sh8000, 1'b0, NO_RES},
        '{ROW_WRITE, REG_FIR_TAP_ZERO, 16'sh7fff, 1'b0, NO_RES},
        '{ROW_WRITE, REG_FIR_TAP_ONE, 16'sh7fff, 1'b0, NO_RES},
        '{ROW_WRITE, REG_FIR_TAP_TWO, 16'sh7fff, 1'b0, NO_RES},
        '{ROW_WRITE, REG_FIR_TAP_THREE, 16'sh7fff, 1'b0, NO_RES},
        '{ROW_WRITE, REG_FIR_TAP_FOUR, 16'sh7fff, 1'b0, NO_RES},
        '{ROW_WRITE, REG_SPARE, 16'sh8000, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, 16'sh7fff, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, 16'sh7fff, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, 16'sh7fff, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, 16'sh7fff, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, 16'sh7fff, 1'b1, '{16'sh7fff, 16'sh8001, 16'sh7fff}},
        '{ROW_SAMPLE, REG_SPARE, 16'sh8000, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, 16'sh8000, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, 16'sh8000, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, 16'sh8000, 1'b0, NO_RES},
        '{ROW_SAMPLE, REG_SPARE, 16'sh8000, 1'b1, '{16'sh8000, 16'sh7fff, 16'sh8000}}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [SAMPLE_W-1:0]   i_sample_in = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [SAMPLE_W-1:0]   o_average_out;
    logic [SAMPLE_W-1:0]   o_smoothed_out;
    logic [SAMPLE_W-1:0]   o_weighted_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [SAMPLE_W-1:0]   i_cfg_data = '0;

    // filter state as seen by the predictor
    t_sample gain_q15 [NUM_REGS] = RESET_GAINS;
    t_sample avg_ring [AVG_LEN] = '{default: '0};
    int      avg_seen = 0;
    t_sample smooth_prev = '0;
    t_sample fir_window [TAP_COUNT] = '{default: '0};
    int      fir_seen = 0;

    t_filter_result results_due [$];
    t_sample_mark   sample_marks [$];

    int fail_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    sensor_filter_bank_top #(
        .AVERAGE_LENGTH(AVG_LEN)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample_in    (i_sample_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_average_out  (o_average_out),
        .o_smoothed_out (o_smoothed_out),
        .o_weighted_out (o_weighted_out),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_sample clamp16(input longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return t_sample'(v);
    endfunction

    // Advance the filter bank by one sample and produce its result
    task automatic filter_step(input t_sample x, output t_filter_result r);
        longint sum;
        longint acc;
        // moving average: shift the ring, pass through until it is full
        for (int i = 0; i < AVG_LEN - 1; i++) begin
            avg_ring[i] = avg_ring[i + 1];
        end
        avg_ring[AVG_LEN - 1] = x;
        if (avg_seen < AVG_LEN) begin
            r.average = x;
            avg_seen++;
        end else begin
            sum = 0;
            foreach (avg_ring[i]) begin
                sum += avg_ring[i];
            end
            // round half away from zero
            if (sum >= 0) begin
                sum = (sum + AVG_LEN / 2) / AVG_LEN;
            end else begin
                sum = -((-sum + AVG_LEN / 2) / AVG_LEN);
            end
            r.average = clamp16(sum);
        end

        // IIR: Q1.15 mix, round half up via floor of acc + 0.5
        acc = longint'(gain_q15[REG_IIR_OLD_GAIN]) * smooth_prev
            + longint'(gain_q15[REG_IIR_NEW_GAIN]) * x;
        r.smoothed = clamp16((acc + 16384) >>> 15);
        smooth_prev = r.smoothed;

        // FIR: window is oldest first, same warm-up as the average
        for (int i = 0; i < TAP_COUNT - 1; i++) begin
            fir_window[i] = fir_window[i + 1];
        end
        fir_window[TAP_COUNT - 1] = x;
        if (fir_seen < TAP_COUNT) begin
            r.weighted = x;
            fir_seen++;
        end else begin
            acc = 0;
            for (int i = 0; i < TAP_COUNT; i++) begin
                acc += longint'(gain_q15[REG_FIR_TAP_ZERO + i]) * fir_window[i];
            end
            r.weighted = clamp16((acc + 16384) >>> 15);
        end
    endtask

    task automatic check_field(input string name, input t_sample want, input t_sample got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Drive one sample transaction, with an optional random gap before it
    task automatic put_sample(input t_sample s, input bit typed, input t_filter_result res);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        sample_marks.push_back('{typed, res});
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    // Drop the input valid and wait until every due result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_sample value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Randomize the output stall every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Track transactions: apply register writes, predict accepted samples, check results
    always @(posedge i_clk) begin : track_blk
        t_sample_mark   mark;
        t_filter_result predicted;
        t_filter_result want;
        bit             moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                if (i_cfg_index < NUM_REGS) begin
                    gain_q15[i_cfg_index] = i_cfg_data;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                mark = sample_marks.pop_front();
                filter_step(i_sample_in, predicted);
                results_due.push_back(mark.typed ? mark.res : predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (results_due.size() == 0) begin
                    $display("%0t: result with none expected, actual avg %0d smo %0d wgt %0d",
                             $time, $signed(o_average_out), $signed(o_smoothed_out),
                             $signed(o_weighted_out));
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("average_out", want.average, o_average_out);
                    check_field("smoothed_out", want.smoothed, o_smoothed_out);
                    check_field("weighted_out", want.weighted, o_weighted_out);
                end
            end
        end
        // watchdog: abort when nothing moves for too long
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[sensor_filter_bank_top] ERROR");
            $finish;
        end
    end

    initial begin
        t_sample value;
        send_idle_pct = 20;
        recv_idle_pct = 84;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_table[n]) begin
            if (dir_table[n].kind == ROW_WRITE) begin
                drain_results();
                write_reg(dir_table[n].idx, dir_table[n].value);
            end else begin
                put_sample(dir_table[n].value, dir_table[n].typed, dir_table[n].res);
            end
        end

        // random phases, each with its own weight set; phases share idle patterns in pairs
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase / 2)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            // reprogram all weights, plus one write past the map
            for (int r = 0; r <= NUM_REGS; r++) begin
                case (phase)
                    0: value = (r < NUM_REGS) ? RESET_GAINS[r] : t_sample'($urandom);
                    2: value = 16'sh7fff;
                    3: value = 16'sh8000;
                    4: value = t_sample'(int'($urandom_range(8192)) - 4096);
                    default: value = t_sample'($urandom);
                endcase
                drain_results();
                write_reg((r < NUM_REGS) ? r[CFG_IDX_W-1:0] : REG_SPARE, value);
            end

            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                case ($urandom_range(9))
                    0, 1: begin
                        case ($urandom_range(4))
                            0: value = 16'sh7fff;
                            1: value = 16'sh8000;
                            2: value = 16'sd0;
                            3: value = -16'sd1;
                            default: value = 16'sd1;
                        endcase
                    end
                    2, 3, 4: value = t_sample'(int'($urandom_range(2000)) - 1000);
                    default: value = t_sample'($urandom);
                endcase
                put_sample(value, 1'b0, NO_RES);
            end
        end

        drain_results();
        // hold on a while longer to catch stray results
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[sensor_filter_bank_top] OK");
        end else begin
            $display("[sensor_filter_bank_top] ERROR");
        end
        $finish;
    end

endmodule
